[hw/rtl/fog_density_map_engine_core_macros.svh]
// assertion helpers shared by the block
`ifndef FOG_DENSITY_MAP_ENGINE_CORE_MACROS_SVH
`define FOG_DENSITY_MAP_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FDME_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FDME_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

`endif

[hw/rtl/fdme_pkg.sv]
`timescale 1ns / 1ps
package fdme_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_TICK   = 2'd1,
        OP_STAMP  = 2'd2,
        OP_SAMPLE = 2'd3
    } t_op;

    localparam logic CFG_GAIN  = 1'b0;
    localparam logic CFG_SHIFT = 1'b1;

    localparam logic [7:0] GAIN_RESET  = 8'd192;
    localparam logic [2:0] SHIFT_RESET = 3'd3;

    localparam logic [4:0] SQRT_LAST = 5'd17;
    localparam logic [4:0] DIV_LAST  = 5'd7;
    localparam logic [4:0] TAP_LAST  = 5'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_TK_RD,
        S_TK_WR,
        S_SP_INIT,
        S_SP_SQRT,
        S_SP_CHK,
        S_SP_MUL,
        S_SP_DIV,
        S_SP_WR,
        S_SM_INIT,
        S_SM_RD,
        S_SM_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       wr_cell;
        logic       tk_wr;
        logic       sp_init;
        logic       sp_sqrt;
        logic       sp_mul;
        logic       sp_div;
        logic       sp_wr;
        logic       sm_init;
        logic       sm_rd;
        logic       sm_acc;
        logic [1:0] sel;
        logic [7:0] x;
        logic [7:0] z;
    } t_cmd;

    typedef struct packed {
        logic dist_lt_r;
    } t_sts;

endpackage

[hw/rtl/fdme_ctrl.sv]
`timescale 1ns / 1ps
module fdme_ctrl #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_op,
    output logic            o_ready,
    input  logic            i_slot_free,
    output logic            o_done,
    output logic [1:0]      o_op,
    output fdme_pkg::t_cmd  o_cmd,
    input  fdme_pkg::t_sts  i_sts
);

    fdme_pkg::t_state r_state, n_state;
    logic [7:0] r_x, n_x, r_z, n_z;
    logic [4:0] r_step, n_step;
    logic [1:0] r_op, n_op;
    logic       last_cell;

    assign last_cell = (r_x == 8'(MAP_WIDTH - 1)) && (r_z == 8'(MAP_HEIGHT - 1));
    assign o_op = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdme_pkg::S_CLEAR;
            r_x     <= '0;
            r_z     <= '0;
            r_step  <= '0;
            r_op    <= '0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_z     <= n_z;
            r_step  <= n_step;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_z     = r_z;
        n_step  = r_step;
        n_op    = r_op;
        o_ready = 1'b0;
        o_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.x = r_x;
        o_cmd.z = r_z;
        o_cmd.sel = r_step[1:0];
        unique case (r_state)
            fdme_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (last_cell) begin
                    n_state = fdme_pkg::S_IDLE;
                end
            end
            fdme_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_op = i_op;
                    n_x  = '0;
                    n_z  = '0;
                    unique case (fdme_pkg::t_op'(i_op))
                        fdme_pkg::OP_WRITE: n_state = fdme_pkg::S_WRITE;
                        fdme_pkg::OP_TICK:  n_state = fdme_pkg::S_TK_RD;
                        fdme_pkg::OP_STAMP: n_state = fdme_pkg::S_SP_INIT;
                        default:            n_state = fdme_pkg::S_SM_INIT;
                    endcase
                end
            end
            fdme_pkg::S_WRITE: begin
                o_cmd.wr_cell = 1'b1;
                n_state = fdme_pkg::S_DONE;
            end
            fdme_pkg::S_TK_RD: n_state = fdme_pkg::S_TK_WR;
            fdme_pkg::S_TK_WR: begin
                o_cmd.tk_wr = 1'b1;
                n_state = last_cell ? fdme_pkg::S_DONE : fdme_pkg::S_TK_RD;
            end
            fdme_pkg::S_SP_INIT: begin
                o_cmd.sp_init = 1'b1;
                n_step  = '0;
                n_state = fdme_pkg::S_SP_SQRT;
            end
            fdme_pkg::S_SP_SQRT: begin
                o_cmd.sp_sqrt = 1'b1;
                n_step = r_step + 5'd1;
                if (r_step == fdme_pkg::SQRT_LAST) begin
                    n_state = fdme_pkg::S_SP_CHK;
                end
            end
            fdme_pkg::S_SP_CHK: begin
                if (i_sts.dist_lt_r) begin
                    n_state = fdme_pkg::S_SP_MUL;
                end else begin
                    n_state = last_cell ? fdme_pkg::S_DONE : fdme_pkg::S_SP_INIT;
                end
            end
            fdme_pkg::S_SP_MUL: begin
                o_cmd.sp_mul = 1'b1;
                n_step  = '0;
                n_state = fdme_pkg::S_SP_DIV;
            end
            fdme_pkg::S_SP_DIV: begin
                o_cmd.sp_div = 1'b1;
                n_step = r_step + 5'd1;
                if (r_step == fdme_pkg::DIV_LAST) begin
                    n_state = fdme_pkg::S_SP_WR;
                end
            end
            fdme_pkg::S_SP_WR: begin
                o_cmd.sp_wr = 1'b1;
                n_state = last_cell ? fdme_pkg::S_DONE : fdme_pkg::S_SP_INIT;
            end
            fdme_pkg::S_SM_INIT: begin
                o_cmd.sm_init = 1'b1;
                n_step  = '0;
                n_state = fdme_pkg::S_SM_RD;
            end
            fdme_pkg::S_SM_RD: begin
                o_cmd.sm_rd = 1'b1;
                n_state = fdme_pkg::S_SM_ACC;
            end
            fdme_pkg::S_SM_ACC: begin
                o_cmd.sm_acc = 1'b1;
                n_step = r_step + 5'd1;
                n_state = (r_step == fdme_pkg::TAP_LAST) ? fdme_pkg::S_DONE
                                                         : fdme_pkg::S_SM_RD;
            end
            fdme_pkg::S_DONE: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = fdme_pkg::S_IDLE;
                end
            end
            default: n_state = fdme_pkg::S_IDLE;
        endcase

        // raster advance over the map
        if (o_cmd.clr_wr || o_cmd.tk_wr || o_cmd.sp_wr ||
            (r_state == fdme_pkg::S_SP_CHK && !i_sts.dist_lt_r)) begin
            if (r_x == 8'(MAP_WIDTH - 1)) begin
                n_x = '0;
                n_z = last_cell ? 8'd0 : r_z + 8'd1;
            end else begin
                n_x = r_x + 8'd1;
            end
        end
    end

endmodule

[hw/rtl/fdme_dp.sv]
`timescale 1ns / 1ps
module fdme_dp #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [7:0]            i_cfg_data,
    input  logic [11:0]           i_cell_index,
    input  logic [7:0]            i_density_value,
    input  logic [7:0]            i_ceiling_value,
    input  logic signed [15:0]    i_sample_x,
    input  logic signed [15:0]    i_sample_z,
    input  logic signed [7:0]     i_center_x,
    input  logic signed [7:0]     i_center_z,
    input  logic [13:0]           i_radius_q8,
    input  fdme_pkg::t_cmd        i_cmd,
    output fdme_pkg::t_sts        o_sts,
    output logic [6:0]            o_alpha
);

    localparam int CELLS  = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0] r_dens [CELLS];
    logic [7:0] r_ceil [CELLS];
    logic [7:0] r_sub  [CELLS];
    logic [7:0] r_rd_d, r_rd_c, r_rd_s;

    logic [7:0]  r_gain;
    logic [2:0]  r_shift;

    logic [11:0]        r_idx;
    logic [7:0]         r_wd, r_wc;
    logic signed [15:0] r_sx, r_sz;
    logic signed [7:0]  r_cx, r_cz;
    logic [13:0]        r_r;

    logic [35:0] r_n;
    logic [18:0] r_rem;
    logic [17:0] r_root;
    logic [21:0] r_num, r_dvs;
    logic [7:0]  r_q;

    logic [ADDR_W-1:0] r_base;
    logic [7:0]        r_fx, r_fz;
    logic [15:0]       r_w;
    logic [23:0]       r_acc;

    logic [ADDR_W-1:0] addr, cell_addr;
    logic              we_d, we_c, we_s;
    logic [7:0]        wd_d, wd_c, wd_s;

    logic signed [9:0] dx, dz;
    logic [19:0]       dxx, dzz, d2;
    logic [20:0]       rem_t, trial;
    logic signed [17:0] xs, zs;
    logic [15:0]       xc, zc;
    logic [8:0]        d_up, v_sum;
    logic [7:0]        s_dec, gx, gz;
    logic [ADDR_W-1:0] tap_off;

    assign cell_addr = ADDR_W'(int'(i_cmd.z) * MAP_WIDTH + int'(i_cmd.x));
    assign gx = r_fx ^ 8'hff;
    assign gz = r_fz ^ 8'hff;

    always_comb begin
        case (i_cmd.sel)
            2'd0:    tap_off = '0;
            2'd1:    tap_off = ADDR_W'(1);
            2'd2:    tap_off = ADDR_W'(MAP_WIDTH);
            default: tap_off = ADDR_W'(MAP_WIDTH + 1);
        endcase
        if (i_cmd.sm_rd) begin
            addr = r_base + tap_off;
        end else if (i_cmd.wr_cell) begin
            addr = ADDR_W'(r_idx);
        end else begin
            addr = cell_addr;
        end
    end

    // stamp distance, square root step
    always_comb begin
        dx    = $signed({2'b00, i_cmd.x}) - 10'(r_cx);
        dz    = $signed({2'b00, i_cmd.z}) - 10'(r_cz);
        dxx   = 20'(dx) * 20'(dx);
        dzz   = 20'(dz) * 20'(dz);
        d2    = dxx + dzz;
        rem_t = {r_rem, r_n[35:34]};
        trial = {1'b0, r_root, 2'b01};
    end

    // map writes: cell write, clear, tick cell update and stamp accumulate
    always_comb begin
        d_up  = (r_rd_d < r_rd_c) ? {1'b0, r_rd_d} + 9'd1 : {1'b0, r_rd_d};
        s_dec = r_rd_s - (r_rd_s >> r_shift);
        v_sum = {1'b0, r_rd_s} + {1'b0, r_q};
        we_d = 1'b0;
        we_c = 1'b0;
        we_s = 1'b0;
        wd_d = i_density_value;
        wd_c = r_wc;
        wd_s = '0;
        if (i_cmd.wr_cell) begin
            we_d = int'(r_idx) < CELLS;
            we_c = we_d;
            wd_d = r_wd;
        end
        if (i_cmd.tk_wr) begin
            we_d = 1'b1;
            we_s = 1'b1;
            wd_d = (d_up > {1'b0, r_rd_s}) ? 8'(d_up - {1'b0, r_rd_s}) : 8'd0;
            wd_s = (s_dec == 8'd0) ? 8'd0 : s_dec - 8'd1;
        end
        if (i_cmd.clr_wr) begin
            we_s = 1'b1;
        end
        if (i_cmd.sp_wr) begin
            we_s = 1'b1;
            wd_s = v_sum[8] ? 8'hff : v_sum[7:0];
        end
    end

    // sample position clamp
    always_comb begin
        xs = {{2{r_sx[15]}}, r_sx} + 18'(MAP_WIDTH * 128);
        zs = {{2{r_sz[15]}}, r_sz} + 18'(MAP_HEIGHT * 128);
        if (xs[17]) begin
            xc = '0;
        end else if (xs > 18'((MAP_WIDTH - 2) * 256)) begin
            xc = 16'((MAP_WIDTH - 2) * 256);
        end else begin
            xc = xs[15:0];
        end
        if (zs[17]) begin
            zc = '0;
        end else if (zs > 18'((MAP_HEIGHT - 2) * 256)) begin
            zc = 16'((MAP_HEIGHT - 2) * 256);
        end else begin
            zc = zs[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_d <= r_dens[addr];
        r_rd_c <= r_ceil[addr];
        r_rd_s <= r_sub[addr];
        if (we_d) r_dens[addr] <= wd_d;
        if (we_c) r_ceil[addr] <= wd_c;
        if (we_s) r_sub[addr]  <= wd_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= fdme_pkg::GAIN_RESET;
            r_shift <= fdme_pkg::SHIFT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == fdme_pkg::CFG_GAIN) r_gain <= i_cfg_data;
            if (i_cfg_addr == fdme_pkg::CFG_SHIFT) r_shift <= i_cfg_data[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= i_cell_index;
            r_wd  <= i_density_value;
            r_wc  <= i_ceiling_value;
            r_cx  <= i_center_x;
            r_cz  <= i_center_z;
            r_r   <= i_radius_q8;
            r_sx  <= i_sample_x;
            r_sz  <= i_sample_z;
        end
        if (i_cmd.sp_init) begin
            r_n    <= {d2, 16'h0000};
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sp_sqrt) begin
            r_n <= {r_n[33:0], 2'b00};
            if (rem_t >= trial) begin
                r_rem  <= 19'(rem_t - trial);
                r_root <= {r_root[16:0], 1'b1};
            end else begin
                r_rem  <= rem_t[18:0];
                r_root <= {r_root[16:0], 1'b0};
            end
        end
        if (i_cmd.sp_mul) begin
            r_num <= {14'd0, r_gain} * {8'd0, (r_r - r_root[13:0])};
            r_dvs <= {1'b0, r_r, 7'b0};
            r_q   <= '0;
        end
        if (i_cmd.sp_div) begin
            r_dvs <= r_dvs >> 1;
            if (r_num >= r_dvs) begin
                r_num <= r_num - r_dvs;
                r_q   <= {r_q[6:0], 1'b1};
            end else begin
                r_q   <= {r_q[6:0], 1'b0};
            end
        end
        if (i_cmd.sm_init) begin
            r_base <= ADDR_W'(int'(zc[15:8]) * MAP_WIDTH + int'(xc[15:8]));
            r_fx   <= xc[7:0];
            r_fz   <= zc[7:0];
            r_acc  <= '0;
        end
        if (i_cmd.sm_rd) begin
            case (i_cmd.sel)
                2'd0:    r_w <= gx * gz;
                2'd1:    r_w <= r_fx * gz;
                2'd2:    r_w <= gx * r_fz;
                default: r_w <= r_fx * r_fz;
            endcase
        end
        if (i_cmd.sm_acc) begin
            r_acc <= r_acc + {16'd0, r_rd_d} * {8'd0, r_w};
        end
    end

    assign o_sts.dist_lt_r = r_root < {4'b0000, r_r};
    assign o_alpha = r_acc[23:17];

endmodule

[hw/rtl/fog_density_map_engine_core.sv]
`timescale 1ns / 1ps
// fog density map engine
// slave stream takes one op word: tuser holds the op (write, tick, stamp,
// sample), tdata holds the operands. every op gives one master word with
// the op echoed in tuser and the sampled alpha in tdata (zero for other ops).
// the config channel writes stamp_gain (index 0) and decay_shift (index 1),
// taken in any cycle; write it only while the block is idle.
// each op walks the map memories under the controller before the next word
// is accepted:
//   write   one cell write of the density and ceiling maps
//   sample  four density taps, read then accumulate each
//   tick    a read then a write for every cell
//   stamp   for every cell 18 root steps and a radius check; cells inside the
//           radius add a multiply, 8 divide steps and a write.
// one op is worked at a time; the next word is taken once the result sits in
// the output register, so the block keeps working while the receiver stalls
// until a second result would have to wait.
// after reset the subtraction map is cleared one cell a cycle with s_tready low;
// config writes are taken during that pass.
module fog_density_map_engine_core #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [11:0] cell_index, [19:12] density_value, [27:20] ceiling_value,
    // [43:28] sample_x, [59:44] sample_z, [67:60] center_x,
    // [75:68] center_z, [89:76] radius_q8, [95:90] zero
    input  logic [95:0] i_s_tdata,
    // [1:0] op
    input  logic [1:0]  i_s_tuser,
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [6:0] alpha, [7] zero
    output logic [7:0]  o_m_tdata,
    // [1:0] op_done
    output logic [1:0]  o_m_tuser,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

`include "fog_density_map_engine_core_macros.svh"

    fdme_pkg::t_cmd cmd;
    fdme_pkg::t_sts sts;
    logic       done;
    logic [1:0] op;
    logic [6:0] alpha;
    logic       slot_free;
    logic       s_acc;

    // output word register
    logic       r_out_valid;
    logic [1:0] r_out_op;
    logic [6:0] r_out_alpha;

    assign slot_free   = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;

    fdme_ctrl #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_op        (i_s_tuser),
        .o_ready     (o_s_tready),
        .i_slot_free (slot_free),
        .o_done      (done),
        .o_op        (op),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    fdme_dp #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_cell_index    (i_s_tdata[11:0]),
        .i_density_value (i_s_tdata[19:12]),
        .i_ceiling_value (i_s_tdata[27:20]),
        .i_sample_x      (i_s_tdata[43:28]),
        .i_sample_z      (i_s_tdata[59:44]),
        .i_center_x      (i_s_tdata[67:60]),
        .i_center_z      (i_s_tdata[75:68]),
        .i_radius_q8     (i_s_tdata[89:76]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_alpha         (alpha)
    );

    // result lands here; alpha only meaningful for a sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_op    <= op;
            r_out_alpha <= (op == fdme_pkg::OP_SAMPLE) ? alpha : 7'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_alpha};
    assign o_m_tuser  = r_out_op;

    // a finished op never overwrites a word still waiting
    `FDME_ASSERT_SAME(a_done_slot, i_clk, i_rst_n, done, slot_free, "result overwrite")
    // the block is busy right after taking a word
    `FDME_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, s_acc, !o_s_tready, "accept while busy")
    // non-sample results carry zero alpha
    `FDME_ASSERT_SAME(a_alpha_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != fdme_pkg::OP_SAMPLE), o_m_tdata == 8'd0, "alpha not zero")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam int W = 64;
    localparam int H = 64;
    localparam int CELLS = W * H;
    // slowest op is a stamp, with a square root walk for every cell; allow wide margin
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef struct {
        fdme_pkg::t_op    op;
        logic [11:0]      cell_index;
        logic [7:0]       density_value;
        logic [7:0]       ceiling_value;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_z;
        logic signed [7:0]  center_x;
        logic signed [7:0]  center_z;
        logic [13:0]      radius_q8;
    } t_fog_op;

    typedef struct {
        fdme_pkg::t_op op;
        logic [6:0]    alpha;
    } t_fog_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_data;

    // shadow copy of the maps and registers
    logic [7:0] dens_shadow [CELLS];
    logic [7:0] ceiling_map [CELLS];
    logic [7:0] subtract_map [CELLS];
    logic [7:0] gain_reg;
    logic [2:0] shift_reg;

    t_fog_result pending_results[$];
    int     mismatches;
    int     results_seen;
    int     ops_sent;
    int     stamps_sent;
    int     ticks_sent;
    int     samples_sent;
    int     burst_left;
    longint cycles;

    fog_density_map_engine_core #(.MAP_WIDTH(W), .MAP_HEIGHT(H)) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floored integer square root
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe >>= 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic void step_map();
        int d;
        int s;
        for (int i = 0; i < CELLS; i++) begin
            d = dens_shadow[i];
            s = subtract_map[i];
            if (d < int'(ceiling_map[i])) d++;
            d -= s;
            if (d < 0) d = 0;
            dens_shadow[i] = d[7:0];
            s = s - (s >> shift_reg) - 1;
            if (s < 0) s = 0;
            subtract_map[i] = s[7:0];
        end
    endfunction

    function automatic void stamp_map(int cx, int cz, int r);
        longint dx;
        longint dz;
        longint unsigned reach;
        int add;
        int v;
        if (r == 0) return;
        for (int z = 0; z < H; z++) begin
            for (int x = 0; x < W; x++) begin
                dx = x - cx;
                dz = z - cz;
                reach = int_sqrt(longint'(dx * dx + dz * dz) << 16);
                if (reach < longint'(r)) begin
                    add = (int'(gain_reg) * (r - int'(reach))) / r;
                    v = int'(subtract_map[z * W + x]) + add;
                    subtract_map[z * W + x] = (v > 255) ? 8'd255 : v[7:0];
                end
            end
        end
    endfunction

    function automatic logic [6:0] sample_map(int sx, int sz);
        int x;
        int z;
        int unsigned fx, fz, gx, gz, base, acc;
        x = sx + (W / 2) * 256;
        z = sz + (H / 2) * 256;
        if (x < 0) x = 0;
        if (z < 0) z = 0;
        if (x > (W - 2) * 256) x = (W - 2) * 256;
        if (z > (H - 2) * 256) z = (H - 2) * 256;
        fx = x & 255;
        fz = z & 255;
        gx = fx ^ 255;
        gz = fz ^ 255;
        base = (x >> 8) + (z >> 8) * W;
        acc = dens_shadow[base] * gx * gz + dens_shadow[base + 1] * fx * gz
            + dens_shadow[base + W] * gx * fz + dens_shadow[base + W + 1] * fx * fz;
        return acc[23:17];
    endfunction

    // work out the result of one accepted op and update the shadow maps
    function automatic t_fog_result apply_op(t_fog_op f);
        t_fog_result r;
        r.op = f.op;
        r.alpha = '0;
        case (f.op)
            fdme_pkg::OP_WRITE: begin
                dens_shadow[f.cell_index] = f.density_value;
                ceiling_map[f.cell_index] = f.ceiling_value;
            end
            fdme_pkg::OP_TICK: step_map();
            fdme_pkg::OP_STAMP: stamp_map(f.center_x, f.center_z, f.radius_q8);
            fdme_pkg::OP_SAMPLE: r.alpha = sample_map(f.sample_x, f.sample_z);
        endcase
        return r;
    endfunction

    // send one op word, bursts of random length with random gaps
    task automatic send_op(t_fog_op f);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= f.op;
        i_s_tdata  <= {6'd0, f.radius_q8, f.center_z, f.center_x, f.sample_z,
                       f.sample_x, f.ceiling_value, f.density_value, f.cell_index};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(apply_op(f));
        ops_sent++;
        case (f.op)
            fdme_pkg::OP_TICK:   ticks_sent++;
            fdme_pkg::OP_STAMP:  stamps_sent++;
            fdme_pkg::OP_SAMPLE: samples_sent++;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == fdme_pkg::CFG_GAIN) gain_reg = value;
        else shift_reg = value[2:0];
    endtask

    function automatic t_fog_op blank_op(fdme_pkg::t_op op);
        t_fog_op f;
        f = '{op: op, default: '0};
        f.cell_index    = 12'($urandom);
        f.density_value = 8'($urandom);
        f.ceiling_value = 8'($urandom);
        f.sample_x      = 16'($urandom);
        f.sample_z      = 16'($urandom);
        f.center_x      = 8'($urandom);
        f.center_z      = 8'($urandom);
        return f;
    endfunction

    task automatic send_sample(int sx, int sz);
        t_fog_op f;
        f = blank_op(fdme_pkg::OP_SAMPLE);
        f.sample_x = 16'(sx);
        f.sample_z = 16'(sz);
        send_op(f);
    endtask

    task automatic send_stamp(int cx, int cz, int r);
        t_fog_op f;
        f = blank_op(fdme_pkg::OP_STAMP);
        f.center_x  = 8'(cx);
        f.center_z  = 8'(cz);
        f.radius_q8 = 14'(r);
        send_op(f);
    endtask

    task automatic send_write(int idx, int dv, int cv);
        t_fog_op f;
        f = blank_op(fdme_pkg::OP_WRITE);
        f.cell_index    = 12'(idx);
        f.density_value = 8'(dv);
        f.ceiling_value = 8'(cv);
        send_op(f);
    endtask

    // every cell is loaded before anything reads the density or ceiling maps
    task automatic test_fill_map();
        for (int i = 0; i < CELLS; i++)
            send_write(i, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic test_write_and_sample_extremes();
        send_write(0, 255, 255);
        send_write(CELLS - 1, 0, 0);
        send_write(1, 255, 0);
        send_write(W, 0, 255);
        send_sample(-32768, -32768);   // clamps to the first cell
        send_sample(32767, 32767);     // clamps near the far corner, cell (62, 62)
        send_sample(-32 * 256, -32 * 256);
        send_sample(30 * 256 + 255, 30 * 256 + 255);
        send_sample(-32 * 256 + 128, -32 * 256 + 1);
        send_sample(0, 0);
    endtask

    task automatic test_ticks();
        t_fog_op f;
        f = blank_op(fdme_pkg::OP_TICK);
        send_op(f);
        send_sample(-32 * 256, -32 * 256);
        send_op(f);
    endtask

    task automatic test_stamps();
        send_stamp(10, 12, 0);         // zero radius leaves the map alone
        send_stamp(-64, 127, 16 * 256);// center off the map, out of reach of every cell
        send_stamp(32, 32, 1);         // tiny radius, only the center cell
        send_stamp(5, 60, 16383);      // wide radius, covers most of the map, saturates
        send_sample(0, 0);
        send_op(blank_op(fdme_pkg::OP_TICK));
        send_sample(-27 * 256 + 77, 28 * 256 + 3);
    endtask

    // register phases, extremes first; always entered with the block idle
    task automatic test_config_phase(logic [7:0] gain, logic [7:0] shift);
        drain_results();
        write_reg(fdme_pkg::CFG_GAIN, gain);
        write_reg(fdme_pkg::CFG_SHIFT, shift);
        send_stamp($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(256, 2560));
        repeat (3) send_op(blank_op(fdme_pkg::OP_TICK));
        send_sample($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
    endtask

    task automatic test_random(int n);
        t_fog_op f;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 44) begin
                f = blank_op(fdme_pkg::OP_WRITE);
            end else if (pick < 92) begin
                f = blank_op(fdme_pkg::OP_SAMPLE);
                // mostly on the map, sometimes anywhere in the field range
                if ($urandom_range(0, 3) != 0) begin
                    f.sample_x = 16'($urandom_range(0, 16895) - 8448);
                    f.sample_z = 16'($urandom_range(0, 16895) - 8448);
                end
            end else begin
                f = blank_op(fdme_pkg::OP_TICK);
            end
            send_op(f);
            if (k == n / 3 || k == 2 * n / 3)
                send_stamp($urandom_range(0, 191) - 64, $urandom_range(0, 191) - 64,
                           $urandom_range(1, 3000));
        end
    endtask

    // receiver stall pattern: a randomly drawn mode sets tready
    logic [1:0] stall_mode;
    always @(posedge i_clk) begin
        if (cycles % 64 == 0) stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= 1'($urandom_range(0, 1));
            2'd2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= (cycles % 8 < 5);
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_fog_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: op %0d alpha %0d", o_m_tuser, o_m_tdata[6:0]);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser != want.op || o_m_tdata[6:0] != want.alpha) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on word %0d: expected op %0d alpha %0d, got op %0d alpha %0d",
                                 results_seen, want.op, want.alpha, o_m_tuser, o_m_tdata[6:0]);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        cycles       = 0;
        stall_mode   = 2'd0;
        mismatches   = 0;
        results_seen = 0;
        ops_sent     = 0;
        stamps_sent  = 0;
        ticks_sent   = 0;
        samples_sent = 0;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_m_tready   = 1'b1;
        i_cfg_valid  = 1'b0;
        i_cfg_addr   = 1'b0;
        i_cfg_data   = '0;
        gain_reg     = fdme_pkg::GAIN_RESET;
        shift_reg    = fdme_pkg::SHIFT_RESET;
        for (int i = 0; i < CELLS; i++) begin
            dens_shadow[i]  = '0;
            ceiling_map[i]  = '0;
            subtract_map[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_map();
        test_write_and_sample_extremes();
        test_ticks();
        test_stamps();
        test_config_phase(8'd255, 8'd1);
        test_config_phase(8'd0, 8'd7);
        test_config_phase(8'd1, 8'd0);     // zero shift clears on each tick
        test_config_phase(8'($urandom_range(2, 254)), 8'($urandom_range(1, 7)));
        test_random(100);
        drain_results();

        $display("ran %0d ops in %0d cycles: %0d stamps, %0d ticks, %0d samples",
                 ops_sent, cycles, stamps_sent, ticks_sent, samples_sent);
        $display("covered register extremes, clamped samples and off-map stamps; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fdme_pkg.sv
hw/rtl/fdme_ctrl.sv
hw/rtl/fdme_dp.sv
hw/rtl/fog_density_map_engine_core.sv
sim/tb_top.sv
